// ----- design/stk_pkg.sv -----
package stk_pkg;

    localparam int VAL_W     = 32;
    localparam int SEQ_W     = 32;
    localparam int SLOT_W    = 6;
    localparam int SLOTS_DEF = 64;

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [SEQ_W-1:0]        t_seq;
    typedef logic [SLOT_W-1:0]       t_slot;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam t_value VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_seq   SEQ_MAX = {SEQ_W{1'b1}};

endpackage

// ----- design/stk_if.sv -----
interface stk_in_if
    import stk_pkg::*;
    ();
    logic   valid;
    logic   ready;
    logic   op;
    t_value sample_value;
    t_slot  read_slot;

    modport source (output valid, output op, output sample_value, output read_slot,
                    input ready);
    modport sink   (input valid, input op, input sample_value, input read_slot,
                    output ready);
endinterface

interface stk_out_if
    import stk_pkg::*;
    ();
    logic   valid;
    logic   ready;
    logic   accepted;
    logic   slot_filled;
    t_seq   slot_sequence;
    t_value slot_value;

    modport source (output valid, output accepted, output slot_filled,
                    output slot_sequence, output slot_value, input ready);
    modport sink   (input valid, input accepted, input slot_filled,
                    input slot_sequence, input slot_value, output ready);
endinterface

// ----- design/stk_cell.sv -----
module stk_cell
    import stk_pkg::*;
#(
    parameter int IW = 6,
    parameter int K  = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [IW-1:0] i_wr_idx,
    input  t_value        i_wr_val,
    input  logic          i_scan_vld,
    input  t_value        i_scan_val,
    input  logic [IW-1:0] i_scan_idx,
    output logic          o_scan_vld,
    output t_value        o_scan_val,
    output logic [IW-1:0] o_scan_idx
);

    t_value        r_val;
    logic          r_vld;
    t_value        r_cand_val;
    logic [IW-1:0] r_cand_idx;

    always_ff @(posedge i_clk) begin
        if (i_wr && (i_wr_idx == IW'(K))) begin
            r_val <= i_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_scan_vld;
        end
    end

    // take over the candidate only on a strictly smaller value: lowest slot wins ties
    always_ff @(posedge i_clk) begin
        if (i_scan_vld) begin
            if (r_val < i_scan_val) begin
                r_cand_val <= r_val;
                r_cand_idx <= IW'(K);
            end else begin
                r_cand_val <= i_scan_val;
                r_cand_idx <= i_scan_idx;
            end
        end
    end

    assign o_scan_vld = r_vld;
    assign o_scan_val = r_cand_val;
    assign o_scan_idx = r_cand_idx;

endmodule

// ----- design/stk_chain.sv -----
module stk_chain
    import stk_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [IW-1:0] i_wr_idx,
    input  t_value        i_wr_val,
    input  logic          i_start,
    output logic          o_done,
    output t_value        o_min_val,
    output logic [IW-1:0] o_min_idx
);

    logic          w_vld [SLOTS+1];
    t_value        w_val [SLOTS+1];
    logic [IW-1:0] w_idx [SLOTS+1];

    // seed the scan with the largest value so cell 0 always takes it
    assign w_vld[0] = i_start;
    assign w_val[0] = VAL_MAX;
    assign w_idx[0] = '0;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        stk_cell #(
            .IW (IW),
            .K  (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (i_wr),
            .i_wr_idx   (i_wr_idx),
            .i_wr_val   (i_wr_val),
            .i_scan_vld (w_vld[k]),
            .i_scan_val (w_val[k]),
            .i_scan_idx (w_idx[k]),
            .o_scan_vld (w_vld[k+1]),
            .o_scan_val (w_val[k+1]),
            .o_scan_idx (w_idx[k+1])
        );
    end

    assign o_done    = w_vld[SLOTS];
    assign o_min_val = w_val[SLOTS];
    assign o_min_idx = w_idx[SLOTS];

endmodule

// ----- design/streaming_top_k_selector.sv -----
// Channel   Port    Dir  Payload
// --------  ------  ---  ----------------------------------------------------
// request   i_in    in   op, sample_value, read_slot
// result    o_out   out  accepted, slot_filled, slot_sequence, slot_value
//
// A read, a push while slots are still free, and a discarded push go through the idle
// and execute states only. A push that stores into the last free slot or replaces a
// kept sample also enters the scan state: the worst slot is refreshed by a scan token
// passing one cell a cycle through the SLOTS cells of the chain.
// Synchronous active-low reset empties all slots and zeroes the sequence counter.
// The result register takes the next result only once the previous one has left.
module streaming_top_k_selector
    import stk_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    stk_in_if.sink    i_in,
    stk_out_if.source o_out
);

    localparam int IW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]    r_state, n_state;
    logic          r_op;
    t_value        r_in_val;
    t_slot         r_in_slot;
    logic [FW-1:0] r_filled, n_filled;
    t_seq          r_next_seq, n_next_seq;
    t_value        r_worst_val;
    logic [IW-1:0] r_worst_idx;
    logic          r_scan_start, n_scan_start;

    logic          r_out_valid, n_out_valid;
    logic          r_out_acc;
    logic          r_out_filled;
    t_seq          r_out_seq;
    t_value        r_out_val;

    t_value        mem_val [SLOTS];
    t_seq          mem_seq [SLOTS];
    t_value        r_rd_val;
    t_seq          r_rd_seq;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_exec;
    logic                w_full;
    logic                w_take;
    logic                w_wr;
    logic [IW-1:0]       w_wr_idx;
    logic [IW+SLOT_W-1:0] w_rd_wide;
    logic [IW-1:0]       w_rd_addr;
    logic [31:0]         w_slot_ext;
    logic                w_slot_ok;
    logic                w_done;
    t_value              w_min_val;
    logic [IW-1:0]       w_min_idx;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_exec     = (r_state == ST_EXEC) && w_out_free;

    assign w_full   = (r_filled == FW'(SLOTS));
    assign w_take   = !w_full || (r_in_val > r_worst_val);
    assign w_wr     = w_exec && (r_op == OP_PUSH) && w_take;
    assign w_wr_idx = w_full ? r_worst_idx : r_filled[IW-1:0];

    assign w_rd_wide = {{IW{1'b0}}, i_in.read_slot};
    assign w_rd_addr = w_rd_wide[IW-1:0];

    assign w_slot_ext = 32'(r_in_slot);
    assign w_slot_ok  = (w_slot_ext < 32'(SLOTS)) && (w_slot_ext < 32'(r_filled));

    stk_chain #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_wr_idx  (w_wr_idx),
        .i_wr_val  (r_in_val),
        .i_start   (r_scan_start),
        .o_done    (w_done),
        .o_min_val (w_min_val),
        .o_min_idx (w_min_idx)
    );

    always_comb begin
        n_state      = r_state;
        n_filled     = r_filled;
        n_next_seq   = r_next_seq;
        n_scan_start = 1'b0;
        n_out_valid  = r_out_valid && !o_out.ready;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_op == OP_PUSH) begin
                        if (r_next_seq != SEQ_MAX) begin
                            n_next_seq = r_next_seq + 1'b1;
                        end
                        if (!w_full) begin
                            n_filled = r_filled + 1'b1;
                        end
                        // refresh the worst slot whenever a full set has changed
                        if (w_take && (w_full || (r_filled == FW'(SLOTS - 1)))) begin
                            n_state      = ST_SCAN;
                            n_scan_start = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_filled     <= '0;
            r_next_seq   <= '0;
            r_scan_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_filled     <= n_filled;
            r_next_seq   <= n_next_seq;
            r_scan_start <= n_scan_start;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= i_in.op;
            r_in_val  <= i_in.sample_value;
            r_in_slot <= i_in.read_slot;
            r_rd_val  <= mem_val[w_rd_addr];
            r_rd_seq  <= mem_seq[w_rd_addr];
        end
        if (w_wr) begin
            mem_val[w_wr_idx] <= r_in_val;
            mem_seq[w_wr_idx] <= r_next_seq;
        end
        if ((r_state == ST_SCAN) && w_done) begin
            r_worst_val <= w_min_val;
            r_worst_idx <= w_min_idx;
        end
        if (w_exec) begin
            if (r_op == OP_PUSH) begin
                r_out_acc    <= w_take;
                r_out_filled <= 1'b0;
                r_out_seq    <= '0;
                r_out_val    <= '0;
            end else begin
                r_out_acc    <= 1'b0;
                r_out_filled <= w_slot_ok;
                r_out_seq    <= w_slot_ok ? r_rd_seq : '0;
                r_out_val    <= w_slot_ok ? r_rd_val : '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out_acc;
    assign o_out.slot_filled   = r_out_filled;
    assign o_out.slot_sequence = r_out_seq;
    assign o_out.slot_value    = r_out_val;

    a_no_accept_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !i_in.ready)
        else $error("item accepted during worst-slot scan");

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FW'(SLOTS))
        else $error("fill count beyond slot count");

    a_scan_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_SCAN))
        else $error("scan token left the chain outside a scan");

    a_push_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> !o_out.slot_filled)
        else $error("push result carries read fields");

    a_scan_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_start |-> ((r_state == ST_SCAN) && (r_filled == FW'(SLOTS))))
        else $error("scan started with free slots");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import stk_pkg::*;
    ();

    localparam int     SLOTS       = SLOTS_DEF;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     RANDOM_ITEMS = 1700;
    localparam t_value VAL_MIN     = ~VAL_MAX;

    typedef struct {
        logic   accepted;
        logic   slot_filled;
        t_seq   slot_sequence;
        t_value slot_value;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    stk_in_if  in_if ();
    stk_out_if out_if ();

    streaming_top_k_selector #(.SLOTS(SLOTS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow copy of the kept samples
    t_value  kept_val [SLOTS];
    t_seq    kept_seq [SLOTS];
    int      filled_cnt = 0;
    t_seq    seq_ctr = '0;

    t_result expected_q [$];
    int      error_cnt = 0;
    int      cycle_cnt = 0;
    int      rx_hold_cycles = 0;
    bit      no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Lowest slot holding the smallest kept value
    function automatic int worst_slot();
        int w;
        w = 0;
        for (int k = 1; k < SLOTS; k++) begin
            if (kept_val[k] < kept_val[w])
                w = k;
        end
        return w;
    endfunction

    function automatic t_result predict_step(logic op, t_value val, t_slot slot);
        t_result r;
        int      w;
        r = '{default: '0};
        if (op == OP_PUSH) begin
            if (filled_cnt < SLOTS) begin
                kept_val[filled_cnt] = val;
                kept_seq[filled_cnt] = seq_ctr;
                filled_cnt++;
                r.accepted = 1'b1;
            end else begin
                w = worst_slot();
                if (val > kept_val[w]) begin
                    kept_val[w] = val;
                    kept_seq[w] = seq_ctr;
                    r.accepted = 1'b1;
                end
            end
            if (seq_ctr != SEQ_MAX)
                seq_ctr++;
        end else if (int'(slot) < filled_cnt) begin
            r.slot_filled   = 1'b1;
            r.slot_sequence = kept_seq[slot];
            r.slot_value    = kept_val[slot];
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_cnt++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
        end
    endtask

    // Predict on each accepted item, compare each delivered result
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                expected_q.push_back(predict_step(in_if.op, in_if.sample_value,
                                                  in_if.read_slot));
            if (out_if.valid && out_if.ready) begin
                if (expected_q.size() == 0) begin
                    error_cnt++;
                    $display("%0t: unexpected result, expected none, actual %b %b %h %h",
                             $realtime, out_if.accepted, out_if.slot_filled,
                             out_if.slot_sequence, out_if.slot_value);
                end else begin
                    want = expected_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(out_if.accepted));
                    check_field("slot_filled", 32'(want.slot_filled),
                                32'(out_if.slot_filled));
                    check_field("slot_sequence", want.slot_sequence, out_if.slot_sequence);
                    check_field("slot_value", want.slot_value, out_if.slot_value);
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid && rx_hold_cycles == 0);
        end
    end

    task automatic send_item(logic op, t_value val, t_slot slot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.sample_value <= val;
        in_if.read_slot    <= slot;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Mix of wide random values, extremes, ties and values close to the current floor
    function automatic t_value pick_value();
        t_value w;
        w = (filled_cnt == SLOTS) ? kept_val[worst_slot()] : t_value'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: return t_value'($urandom);
            3: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            4: return t_value'($urandom_range(0, 8)) - t_value'(4);
            5, 6, 7: return w + t_value'($urandom_range(0, 3)) - t_value'(1);
            8: return kept_val[$urandom_range(0, SLOTS - 1)];
            default: return t_value'({1'b0, 31'($urandom)});
        endcase
    endfunction

    task automatic test_empty_reads();
        send_item(OP_READ, t_value'($urandom), t_slot'(0));
        send_item(OP_READ, t_value'($urandom), t_slot'(SLOTS - 1));
        send_item(OP_READ, t_value'($urandom), t_slot'($urandom_range(1, SLOTS - 2)));
    endtask

    task automatic test_push_extremes();
        send_item(OP_PUSH, VAL_MAX, t_slot'($urandom));
        send_item(OP_PUSH, VAL_MIN, t_slot'($urandom));
        send_item(OP_PUSH, '0, t_slot'($urandom));
        send_item(OP_PUSH, '1, t_slot'($urandom));
        send_item(OP_PUSH, t_value'(1), t_slot'($urandom));
        for (int s = 0; s <= 5; s++)
            send_item(OP_READ, t_value'($urandom), t_slot'(s));
        send_item(OP_READ, VAL_MIN, t_slot'(SLOTS - 1));
        // hold the sender until every result is back
        wait_drain();
    endtask

    task automatic test_backpressure();
        wait_drain();
        rx_hold_cycles = 300;
        no_idle = 1'b1;
        for (int n = 0; n < 12; n++)
            send_item(($urandom_range(0, 2) == 0) ? OP_READ : OP_PUSH, pick_value(),
                      t_slot'($urandom));
        no_idle = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_stream();
        logic op;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            op = ($urandom_range(0, 99) < 35) ? OP_READ : OP_PUSH;
            send_item(op, pick_value(), t_slot'($urandom));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_PUSH;
        in_if.sample_value <= '0;
        in_if.read_slot    <= '0;
        for (int k = 0; k < SLOTS; k++) begin
            kept_val[k] = '0;
            kept_seq[k] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_reads();
        test_push_extremes();
        test_backpressure();
        test_random_stream();

        wait_drain();
        repeat (SLOTS + 10) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
